// ===== src/slfe_pkg.sv =====
package slfe_pkg;

	// Field widths fixed by the stream format
	localparam int BYTE_W       = 8;
	localparam int SIG_W        = 64;
	localparam int LEN_W        = 16;
	localparam int OFS_OUT_W    = 32;
	localparam int HDR_BYTES    = 14;
	localparam int SIG_BYTES    = 8;
	localparam int TAIL_BYTES   = HDR_BYTES - SIG_BYTES;
	localparam int BURST_CNT_W  = $clog2(HDR_BYTES + 1);
	localparam int BURST_IDX_W  = $clog2(HDR_BYTES);
	localparam int FILL_W       = $clog2(SIG_BYTES + 1);

	// Defaults for top-level parameters
	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// Reset value of the signature register ("RITE0003", first byte low)
	localparam logic [SIG_W-1:0] SIG_RESET = 64'h3330_3030_4554_4952;

	// Scanner modes
	typedef enum logic [1:0] {
		MODE_SCAN   = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_BODY   = 2'd2
	} mode_t;

	// Input word
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} in_word_t;

	// Output word
	typedef struct packed {
		logic [BYTE_W-1:0]    out_byte;
		logic [OFS_OUT_W-1:0] script_offset;
		logic                 last;
		logic                 truncated;
	} out_word_t;

	// One queued job: a burst of 1 to 14 bytes sharing one offset and end flags
	typedef struct packed {
		logic [HDR_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [BURST_CNT_W-1:0]           count;
		logic                             last;
		logic                             truncated;
		logic [OFS_OUT_W-1:0]             offset;
	} job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== src/slfe_queue.sv =====
module slfe_queue
	import slfe_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/slfe_front.sv =====
module slfe_front
	import slfe_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SIG_W-1:0] signature,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	input  q_stat_t          q_stat,
	output logic             push,
	output job_t             push_job
);

	localparam int OFS_KEEP = (OFFSET_WIDTH < OFS_OUT_W) ? OFFSET_WIDTH : OFS_OUT_W;
	localparam logic [LEN_W-1:0]       LEN_HDR   = LEN_W'(HDR_BYTES);
	localparam logic [LEN_W-1:0]       TAIL_LAST = LEN_W'(TAIL_BYTES - 1);
	localparam logic [FILL_W-1:0]      FILL_FULL = FILL_W'(SIG_BYTES);
	localparam logic [FILL_W-1:0]      FILL_HIT  = FILL_W'(SIG_BYTES - 1);
	localparam logic [BURST_CNT_W-1:0] CNT_HDR   = BURST_CNT_W'(HDR_BYTES);
	localparam logic [BURST_CNT_W-1:0] CNT_PART  = BURST_CNT_W'(SIG_BYTES + 1);
	localparam logic [BURST_CNT_W-1:0] CNT_SIG   = BURST_CNT_W'(SIG_BYTES);

	mode_t                   mode_q, mode_d;
	logic [SIG_W-1:0]        win_q, win_d;
	logic [FILL_W-1:0]       fill_q, fill_d;
	logic [LEN_W-1:0]        cnt_q, cnt_d;
	logic [BYTE_W-1:0]       hdr_q [TAIL_BYTES];
	logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
	logic [OFFSET_WIDTH-1:0] start_q, start_d;

	logic              accept;
	logic [BYTE_W-1:0] b;
	logic              eos;
	logic [SIG_W-1:0]  win_shift;
	logic              hit;
	logic              hdr_done;
	logic [LEN_W-1:0]  len;
	logic              len_short;
	logic              body_end;

	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign b         = in_data.data_byte;
	assign eos       = in_data.end_of_stream;
	assign win_shift = {b, win_q[SIG_W-1:BYTE_W]};
	assign hit       = (fill_q >= FILL_HIT) && (win_shift == signature);
	assign hdr_done  = (cnt_q == TAIL_LAST);
	assign len       = {hdr_q[TAIL_BYTES-2], b};
	assign len_short = (len <= LEN_HDR);
	assign body_end  = (cnt_q <= LEN_W'(1));

	// Next mode
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_HEADER: begin
				if (hdr_done) begin
					if (len_short) mode_d = MODE_SCAN;
					else if (!eos) mode_d = MODE_BODY;
				end
			end
			MODE_BODY: begin
				if (body_end) mode_d = MODE_SCAN;
			end
			default: begin
				mode_d = hit ? MODE_HEADER : MODE_SCAN;
			end
		endcase
		if (eos) mode_d = MODE_SCAN;
	end

	// Datapath update and job build
	always_comb begin
		win_d   = win_q;
		fill_d  = fill_q;
		cnt_d   = cnt_q;
		start_d = start_q;
		pos_d   = eos ? '0 : pos_q + 1'b1;
		push    = 1'b0;

		for (int i = 0; i < SIG_BYTES; i++) begin
			push_job.bytes[i] = win_q[i*BYTE_W +: BYTE_W];
		end
		for (int i = 0; i < TAIL_BYTES; i++) begin
			push_job.bytes[SIG_BYTES+i] = (cnt_q == LEN_W'(i)) ? b : hdr_q[i];
		end
		push_job.count     = CNT_PART + BURST_CNT_W'(cnt_q[2:0]);
		push_job.last      = 1'b1;
		push_job.truncated = 1'b1;

		unique case (mode_q)
			MODE_HEADER: begin
				cnt_d = cnt_q + 1'b1;
				if (hdr_done) begin
					push_job.count = CNT_HDR;
					push           = accept;
					if (len_short) begin
						push_job.truncated = 1'b0;
						win_d  = '0;
						fill_d = '0;
						cnt_d  = '0;
					end else if (!eos) begin
						push_job.last      = 1'b0;
						push_job.truncated = 1'b0;
						cnt_d              = len - LEN_HDR;
					end
				end else begin
					push = accept && eos;
				end
			end
			MODE_BODY: begin
				push_job.bytes[0] = b;
				push_job.count    = BURST_CNT_W'(1);
				push              = accept;
				if (body_end) begin
					push_job.truncated = 1'b0;
					win_d  = '0;
					fill_d = '0;
					cnt_d  = '0;
				end else begin
					push_job.last      = eos;
					push_job.truncated = eos;
					cnt_d              = cnt_q - 1'b1;
				end
			end
			default: begin
				win_d = win_shift;
				if (fill_q < FILL_FULL) fill_d = fill_q + 1'b1;
				for (int i = 0; i < SIG_BYTES; i++) begin
					push_job.bytes[i] = win_shift[i*BYTE_W +: BYTE_W];
				end
				push_job.count = CNT_SIG;
				if (hit) begin
					start_d = pos_q - OFFSET_WIDTH'(SIG_BYTES - 1);
					cnt_d   = '0;
					push    = accept && eos;
				end
			end
		endcase

		push_job.offset = OFS_OUT_W'(start_d[OFS_KEEP-1:0]);

		// Drop scan state at the end of the stream
		if (eos) begin
			win_d  = '0;
			fill_d = '0;
			cnt_d  = '0;
		end
	end

	// Capture header tail bytes
	always_ff @(posedge clk) begin
		if (accept && mode_q == MODE_HEADER) begin
			for (int i = 0; i < TAIL_BYTES; i++) begin
				if (cnt_q == LEN_W'(i)) hdr_q[i] <= b;
			end
		end
	end

	// Hold scanner state between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SCAN;
			win_q   <= '0;
			fill_q  <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			win_q   <= win_d;
			fill_q  <= fill_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			start_q <= start_d;
		end
	end

endmodule

// ===== src/slfe_back.sv =====
module slfe_back
	import slfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  job_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic [BURST_IDX_W-1:0] idx_q;
	logic                   out_valid_q;
	out_word_t              out_data_q;
	logic                   advance;
	logic                   final_byte;

	assign advance    = !q_stat.empty && (!out_valid_q || out_ready);
	assign final_byte = (BURST_CNT_W'(idx_q) == head.count - 1'b1);
	assign pop        = advance && final_byte;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	// Load the output word from the head job
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.out_byte      <= head.bytes[idx_q];
			out_data_q.script_offset <= head.offset;
			out_data_q.last          <= head.last && final_byte;
			out_data_q.truncated     <= head.truncated && final_byte;
		end
	end

	// Step through the burst and track the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= final_byte ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/signature_length_frame_extractor.sv =====
// Channel  Direction  Payload     Handshake
// in       input      in_word_t   in_valid / in_ready
// out      output     out_word_t  out_valid / out_ready
// cfg      input      signature   cfg_valid / cfg_ready (always ready)
//
// The scanner takes one input word per cycle; in_ready drops only while the job
// queue is full. Each header burst of 8 to 14 words drains through the output
// register at one word per cycle while out_ready is high; each body byte goes
// out as a one-word burst. Words pass the job queue, then the output register.
// arst_n clears all control state; the signature returns to "RITE0003".
// A stall on out_ready backs up the queue, then in_ready.
module signature_length_frame_extractor
	import slfe_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SIG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data
);

	logic [SIG_W-1:0] signature_q;
	q_stat_t          q_stat;
	logic             push;
	logic             pop;
	job_t             push_job;
	job_t             head;

	assign cfg_ready = 1'b1;

	// Hold the signature register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signature_q <= SIG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			signature_q <= cfg_data;
		end
	end

	slfe_front #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.signature(signature_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	slfe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	slfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job pushed into full queue");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

	// Truncation is flagged only on a script's final word
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.truncated) |-> out_data.last)
		else $error("truncated word without last");

	// A completed burst frees a slot that input may take next cycle
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> !q_stat.full)
		else $error("queue still full after pop");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import slfe_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_BYTES  = 20;

	// Predicts the extracted script words and holds the ones still due
	class script_checker;
		logic [SIG_W-1:0] sig;
		logic [SIG_W-1:0] window;
		int unsigned      fill;
		mode_t            mode;
		logic [7:0]       hdr [TAIL_BYTES];
		int unsigned      left;
		logic [31:0]      pos;
		logic [31:0]      start;
		out_word_t        due_words [$];
		int               errors;

		function new();
			sig = SIG_RESET;
			pos = '0;
			start = '0;
			errors = 0;
			foreach (hdr[i]) hdr[i] = '0;
			restart();
		endfunction

		function void restart();
			mode = MODE_SCAN;
			fill = 0;
			window = '0;
			left = 0;
		endfunction

		function void push_word(logic [7:0] b, bit last, bit trunc);
			out_word_t w;
			w.out_byte = b;
			w.script_offset = start;
			w.last = last;
			w.truncated = trunc;
			due_words.push_back(w);
		endfunction

		// Release the signature bytes and the first 'stored' tail bytes; flag the final one
		function void push_header(int unsigned stored, bit last, bit trunc);
			int unsigned total;
			logic [7:0]  b;
			bit          fin;
			total = SIG_BYTES + stored;
			for (int unsigned i = 0; i < total; i++) begin
				b = (i < SIG_BYTES) ? window[8*i +: 8] : hdr[i - SIG_BYTES];
				fin = (i + 1 == total);
				push_word(b, fin & last, fin & trunc);
			end
		endfunction

		function void note_stream_byte(in_word_t w);
			logic [7:0]  b;
			bit          eos;
			logic [31:0] at;
			int unsigned len;
			b = w.data_byte;
			eos = w.end_of_stream;
			at = pos;
			pos = pos + 1;
			case (mode)
				MODE_HEADER: begin
					if (left < TAIL_BYTES) hdr[left] = b;
					left++;
					if (left >= TAIL_BYTES) begin
						len = 32'({hdr[4], hdr[5]});
						if (len < HDR_BYTES) len = HDR_BYTES;
						len -= HDR_BYTES;
						if (len == 0) begin
							push_header(TAIL_BYTES, 1, 0);
							restart();
						end else if (eos) begin
							push_header(TAIL_BYTES, 1, 1);
						end else begin
							push_header(TAIL_BYTES, 0, 0);
							mode = MODE_BODY;
							left = len;
						end
					end else if (eos) begin
						push_header(left, 1, 1);
					end
				end
				MODE_BODY: begin
					if (left > 0) left--;
					if (left == 0) begin
						push_word(b, 1, 0);
						restart();
					end else begin
						push_word(b, eos, eos);
					end
				end
				default: begin
					mode = MODE_SCAN;
					window = {b, window[SIG_W-1:8]};
					if (fill < SIG_BYTES) fill++;
					if (fill >= SIG_BYTES && window == sig) begin
						start = at - 7;
						mode = MODE_HEADER;
						left = 0;
						if (eos) push_header(0, 1, 1);
					end
				end
			endcase
			// End of stream starts the next byte at offset zero
			if (eos) begin
				restart();
				pos = '0;
			end
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_script_word(out_word_t got);
			out_word_t want;
			if (due_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %0h", $time, got);
				return;
			end
			want = due_words.pop_front();
			compare("out_byte", want.out_byte, got.out_byte);
			compare("script_offset", want.script_offset, got.script_offset);
			compare("last", want.last, got.last);
			compare("truncated", want.truncated, got.truncated);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SIG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_word_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b1;
	out_word_t        out_data;

	script_checker    sb = new();
	bit               calm = 0;
	int               quiet_left = 0;
	int               bytes_sent = 0;
	int               cycles = 0;

	signature_length_frame_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check every accepted output word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_script_word(out_data);
	end

	// Stall the output side in bursts, with stretches of steady ready
	always begin
		if (calm) begin
			out_ready <= 1'b1;
			@(posedge clk);
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// Offer one input word, idling first at random, and hold it until accepted
	task automatic send_word(input logic [7:0] b, input bit eos);
		in_word_t w;
		w.data_byte = b;
		w.end_of_stream = eos;
		if (!calm) begin
			if (quiet_left > 0) begin
				quiet_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else if ($urandom_range(0, 7) == 0) begin
				quiet_left = $urandom_range(5, 30);
			end
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_stream_byte(w);
		bytes_sent++;
	endtask

	// Build one script on the current signature; end the stream at byte 'cut' if not negative
	task automatic send_script(input int len, input int cut, input bit broken);
		logic [7:0] bytes [$];
		int         total;
		int         k;
		total = HDR_BYTES + ((len > HDR_BYTES) ? len - HDR_BYTES : 0);
		if (cut >= 0 && cut < total) total = cut + 1;
		for (int i = 0; i < total; i++) begin
			if (i < SIG_BYTES) bytes.push_back(sb.sig[8*i +: 8]);
			else if (i == SIG_BYTES + 4) bytes.push_back(len[15:8]);
			else if (i == SIG_BYTES + 5) bytes.push_back(len[7:0]);
			else bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (broken) begin
			k = $urandom_range(0, SIG_BYTES - 1);
			bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
		end
		foreach (bytes[i]) send_word(bytes[i], (i == cut));
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_word(8'($urandom_range(0, 255)),
				(i == n - 1) && ($urandom_range(0, 4) == 0));
	endtask

	// Let the block drain, then write the signature
	task automatic write_signature(input logic [SIG_W-1:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.sig = value;
	endtask

	// Mostly well-formed scripts with random content, the rest noise and broken ones
	task automatic random_phase();
		int limit;
		int r;
		int len;
		int total;
		int cut;
		limit = bytes_sent + PHASE_BYTES;
		while (bytes_sent < limit) begin
			if ($urandom_range(0, 3) == 0) begin
				send_noise();
			end else begin
				r = $urandom_range(0, 9);
				cut = -1;
				if (r < 2) len = $urandom_range(0, HDR_BYTES - 1);
				else if (r == 2) len = HDR_BYTES;
				else if (r == 3) len = $urandom_range(41, 65535);
				else len = $urandom_range(HDR_BYTES + 1, 40);
				total = HDR_BYTES + ((len > HDR_BYTES) ? len - HDR_BYTES : 0);
				if (r == 3) cut = $urandom_range(0, HDR_BYTES + 10);
				else if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, total - 1);
				else if ($urandom_range(0, 5) == 0) cut = total - 1;
				send_script(len, cut, $urandom_range(0, 9) == 0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short length, stream ends at each stage, extreme bytes
		send_word(8'h00, 0);
		send_word(8'hFF, 0);
		send_word(8'hA5, 1);
		send_script(5, -1, 0);
		send_script(HDR_BYTES + 2, -1, 0);
		send_script(HDR_BYTES + 3, HDR_BYTES + 2, 0);
		send_script(30, SIG_BYTES + 2, 0);
		send_script(30, SIG_BYTES - 1, 0);
		send_script(16'hFFFF, HDR_BYTES + 1, 0);
		send_script(HDR_BYTES, HDR_BYTES - 1, 0);
		send_script(20, HDR_BYTES - 1, 0);
		send_script(HDR_BYTES, -1, 1);

		random_phase();
		write_signature('0);
		repeat (8) send_word(8'h00, 0);
		random_phase();
		write_signature('1);
		random_phase();
		write_signature({$urandom(), $urandom()});
		calm = 1;
		random_phase();

		// Drain and let the block settle
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
